// File: hw/rtl/rbsi_pkg.sv
// Shared types and constants for the ray versus box slab intersection core.
`default_nettype none
package rbsi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_W           = 32;     // quotient / distance word
    localparam int DIV_STEPS     = 32;     // quotient bits resolved, one per stage
    localparam int DIV_LAT       = DIV_STEPS + 2;
    localparam int LANE_LAT      = DIV_LAT + 1;
    localparam int MERGE_LAT     = 2;
    localparam int NUM_LANES     = 3;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_Y = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_Z = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAR   = 3'd6;

    typedef struct packed {
        logic               limit;  // axis constrains the interval
        logic               ok;     // axis does not rule out a hit
        logic signed [31:0] lo;     // entry distance
        logic signed [31:0] hi;     // exit distance
    } lane_t;

endpackage
`default_nettype wire

// File: hw/rtl/ray_box_slab_intersect_core.sv
// Top level of the ray versus axis-aligned box slab intersection core.
//
// Usage:
//   A ray transaction (origin_x/y/z, dir_x/y/z, signed fixed point with
//   FRAC_BITS fraction bits) is taken at any rising edge with start high;
//   busy is tied low, so a new ray may enter every cycle.
//   Three axis lanes work side by side, each with two pipelined dividers
//   that resolve one quotient bit per stage; two merge stages form tNear and
//   tFar and then pick the result.
//   Pipeline: an accepted ray passes 34 divider stages, one lane ordering
//   stage and two merge stages before done is high.
//   Throughput: one ray per cycle, set by the fully pipelined dividers.
//   Results: hit and distance are valid for the single cycle done is high.
//   The receiver cannot stall; results are never held.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr (box
//   corners 0..5, far distance 6); other indexes are ignored. Write only
//   while no ray is in flight.
//   Reset: rst_n clears the in-flight markers, the corners to zero and the
//   far distance to all ones; rays in flight are dropped.
`default_nettype none
module ray_box_slab_intersect_core #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [31:0]              origin_x,
    input  wire logic signed [31:0]              origin_y,
    input  wire logic signed [31:0]              origin_z,
    input  wire logic signed [31:0]              dir_x,
    input  wire logic signed [31:0]              dir_y,
    input  wire logic signed [31:0]              dir_z,
    output logic                                 done,
    output logic                                 hit,
    output logic [30:0]                          distance,
    input  wire logic                            cfg_we,
    input  wire logic [rbsi_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [31:0]                     cfg_wdata
);
    localparam int LAT = rbsi_pkg::LANE_LAT + rbsi_pkg::MERGE_LAT;

    logic signed [31:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [31:0] max_x_reg, max_y_reg, max_z_reg;
    logic [30:0]        far_reg;
    logic [LAT-1:0]     vld_reg;
    logic [LAT-1:0]     vld_next;

    rbsi_pkg::lane_t    lanes [0:rbsi_pkg::NUM_LANES-1];

    assign busy = 1'b0;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            min_z_reg <= '0;
            max_x_reg <= '0;
            max_y_reg <= '0;
            max_z_reg <= '0;
            far_reg   <= 31'h7FFF_FFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rbsi_pkg::CFG_MIN_X: min_x_reg <= cfg_wdata;
                rbsi_pkg::CFG_MIN_Y: min_y_reg <= cfg_wdata;
                rbsi_pkg::CFG_MIN_Z: min_z_reg <= cfg_wdata;
                rbsi_pkg::CFG_MAX_X: max_x_reg <= cfg_wdata;
                rbsi_pkg::CFG_MAX_Y: max_y_reg <= cfg_wdata;
                rbsi_pkg::CFG_MAX_Z: max_z_reg <= cfg_wdata;
                rbsi_pkg::CFG_FAR:   far_reg   <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // in-flight markers, one per pipeline slot
    assign vld_next = {vld_reg[LAT-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign done = vld_reg[LAT-1];

    rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk(clk), .origin(origin_x), .dir(dir_x),
        .corner_min(min_x_reg), .corner_max(max_x_reg), .lane(lanes[0])
    );
    rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk(clk), .origin(origin_y), .dir(dir_y),
        .corner_min(min_y_reg), .corner_max(max_y_reg), .lane(lanes[1])
    );
    rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk(clk), .origin(origin_z), .dir(dir_z),
        .corner_min(min_z_reg), .corner_max(max_z_reg), .lane(lanes[2])
    );

    rbsi_merge u_merge (
        .clk(clk), .lanes(lanes), .far_distance(far_reg),
        .hit(hit), .distance(distance)
    );

    // a result strobe always traces back to an accepted ray
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a ray");

    // every accepted ray comes out after the fixed latency
    a_ray_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("ray lost in pipeline");

    // a hit always reports a positive distance
    a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (distance != 31'd0))
        else $error("hit with zero distance");

endmodule
`default_nettype wire

// File: hw/rtl/rbsi_div.sv
// Pipelined signed fixed-point divider, one quotient bit per stage, saturating.
`default_nettype none
module rbsi_div #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic signed [32:0] num,
    input  wire logic signed [31:0] den,
    output logic signed [31:0]      quo
);
    localparam int NW    = 33 + FRAC_BITS;
    localparam int CW    = 64;
    localparam int STEPS = rbsi_pkg::DIV_STEPS;

    logic [32:0]    nmag;
    logic [31:0]    dmag;
    logic [NW-1:0]  scaled;

    logic [NW-1:0]  rem_reg [0:STEPS];
    logic [31:0]    q_reg   [0:STEPS];
    logic [31:0]    dm_reg  [0:STEPS];
    logic           neg_reg [0:STEPS];
    logic           ovf_reg [0:STEPS];

    assign nmag   = num[32] ? 33'(-num) : 33'(num);
    assign dmag   = den[31] ? 32'(-den) : 32'(den);
    assign scaled = {nmag, {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= scaled;
        q_reg[0]   <= '0;
        dm_reg[0]  <= dmag;
        neg_reg[0] <= num[32] ^ den[31];
        // quotient would need more than 32 bits
        ovf_reg[0] <= {{(CW-NW){1'b0}}, scaled} >= {dmag, 32'd0};
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam int B = STEPS - 1 - i;
        logic [CW-1:0] trial;
        logic          take;
        assign trial = {{(CW-32){1'b0}}, dm_reg[i]} << B;
        assign take  = {{(CW-NW){1'b0}}, rem_reg[i]} >= trial;
        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= take ? rem_reg[i] - trial[NW-1:0] : rem_reg[i];
            q_reg[i+1]   <= q_reg[i] | (take ? (32'd1 << B) : 32'd0);
            dm_reg[i+1]  <= dm_reg[i];
            neg_reg[i+1] <= neg_reg[i];
            ovf_reg[i+1] <= ovf_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (neg_reg[STEPS])
        begin
            if (ovf_reg[STEPS] || q_reg[STEPS] > 32'h8000_0000)
                quo <= rbsi_pkg::SAT_MIN;
            else
                quo <= 32'(-q_reg[STEPS]);
        end
        else
        begin
            if (ovf_reg[STEPS] || q_reg[STEPS] > 32'h7FFF_FFFF)
                quo <= rbsi_pkg::SAT_MAX;
            else
                quo <= q_reg[STEPS];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/rbsi_lane.sv
// One axis slab: two plane distances, zero-direction test, entry/exit ordering.
`default_nettype none
module rbsi_lane #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic signed [31:0] origin,
    input  wire logic signed [31:0] dir,
    input  wire logic signed [31:0] corner_min,
    input  wire logic signed [31:0] corner_max,
    output rbsi_pkg::lane_t         lane
);
    localparam int DL = rbsi_pkg::DIV_LAT;

    logic signed [32:0] num_a;
    logic signed [32:0] num_b;
    logic signed [31:0] qa;
    logic signed [31:0] qb;
    logic signed [31:0] lo_c;
    logic signed [31:0] hi_c;
    logic               in_slab;
    logic               zero_reg    [0:DL-1];
    logic               in_slab_reg [0:DL-1];

    assign num_a = 33'(corner_min) - 33'(origin);
    assign num_b = 33'(corner_max) - 33'(origin);

    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (.clk(clk), .num(num_a), .den(dir), .quo(qa));
    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (.clk(clk), .num(num_b), .den(dir), .quo(qb));

    always_comb
    begin
        if (corner_min < corner_max)
            in_slab = (origin >= corner_min) && (origin <= corner_max);
        else
            in_slab = (origin >= corner_max) && (origin <= corner_min);
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0]    <= (dir == 32'sd0);
        in_slab_reg[0] <= in_slab;
        for (int i = 1; i < DL; i++)
        begin
            zero_reg[i]    <= zero_reg[i-1];
            in_slab_reg[i] <= in_slab_reg[i-1];
        end
    end

    assign lo_c = (qa < qb) ? qa : qb;
    assign hi_c = (qa < qb) ? qb : qa;

    always_ff @(posedge clk)
    begin
        lane.limit <= !zero_reg[DL-1];
        lane.ok    <= !zero_reg[DL-1] || in_slab_reg[DL-1];
        lane.lo    <= lo_c;
        lane.hi    <= hi_c;
    end

endmodule
`default_nettype wire

// File: hw/rtl/rbsi_merge.sv
// Merges the three axis lanes into tNear/tFar and forms hit and distance.
`default_nettype none
module rbsi_merge (
    input  wire logic                  clk,
    input  wire rbsi_pkg::lane_t       lanes [0:rbsi_pkg::NUM_LANES-1],
    input  wire logic [30:0]           far_distance,
    output logic                       hit,
    output logic [30:0]                distance
);
    logic signed [31:0] near_c;
    logic signed [31:0] far_c;
    logic               ok_c;
    logic signed [31:0] near_reg;
    logic signed [31:0] far_reg;
    logic               ok_reg;

    always_comb
    begin
        near_c = rbsi_pkg::SAT_MIN;
        far_c  = rbsi_pkg::SAT_MAX;
        ok_c   = 1'b1;
        for (int i = 0; i < rbsi_pkg::NUM_LANES; i++)
        begin
            ok_c = ok_c && lanes[i].ok;
            if (lanes[i].limit && lanes[i].lo > near_c)
                near_c = lanes[i].lo;
            if (lanes[i].limit && lanes[i].hi < far_c)
                far_c = lanes[i].hi;
        end
    end

    always_ff @(posedge clk)
    begin
        near_reg <= near_c;
        far_reg  <= far_c;
        ok_reg   <= ok_c;
    end

    always_ff @(posedge clk)
    begin
        priority if (!ok_reg || near_reg > far_reg)
        begin
            hit      <= 1'b0;
            distance <= far_distance;
        end
        else if (near_reg > 32'sd0)
        begin
            hit      <= 1'b1;
            distance <= near_reg[30:0];
        end
        else if (far_reg > 32'sd0)
        begin
            hit      <= 1'b1;
            distance <= far_reg[30:0];
        end
        else
        begin
            hit      <= 1'b0;
            distance <= far_distance;
        end
    end

endmodule
`default_nettype wire
